@@ rtl/core/ugb_pkg.sv @@
// Shared types, constants and helper functions for the UTF-8 grapheme boundary marker.
// No dependencies; the core takes everything from here by scoped names.
package ugb_pkg;

    localparam int OFFSET_BITS_DEFAULT = 32;
    localparam int MAX_RESULTS         = 5;
    localparam int RES_IDX_BITS        = 3;
    localparam int CP_BITS             = 21;

    localparam logic [15:0] COMB0_LO = 16'h0300;
    localparam logic [15:0] COMB0_HI = 16'h036F;
    localparam logic [15:0] COMB1_LO = 16'h1AB0;
    localparam logic [15:0] COMB1_HI = 16'h1AFF;
    localparam logic [15:0] COMB2_LO = 16'h1DC0;
    localparam logic [15:0] COMB2_HI = 16'h1DFF;
    localparam logic [15:0] COMB3_LO = 16'h20D0;
    localparam logic [15:0] COMB3_HI = 16'h20FF;
    localparam logic [15:0] COMB4_LO = 16'hFE20;
    localparam logic [15:0] COMB4_HI = 16'hFE2F;

    localparam logic [7:0] CONT_MASK = 8'h3F;
    localparam logic [4:0] LEAD4_TAG = 5'h1E;
    localparam logic [3:0] LEAD3_TAG = 4'hE;
    localparam logic [2:0] LEAD2_TAG = 3'h6;

    typedef struct packed {
        logic [31:0] offset;
        logic [31:0] number;
        logic        eot;
        logic [31:0] total;
    } result_t;

    function automatic logic [2:0] seq_length(input logic [7:0] c);
        logic [2:0] n;
        begin
            n = 3'd1;
            if (c[7:5] == LEAD2_TAG)
            begin
                n = 3'd2;
            end
            else if (c[7:4] == LEAD3_TAG)
            begin
                n = 3'd3;
            end
            else if (c[7:3] == LEAD4_TAG)
            begin
                n = 3'd4;
            end
            return n;
        end
    endfunction

    function automatic logic is_combining(input logic [CP_BITS-1:0] cp);
        logic [15:0] lo;
        logic        hit;
        begin
            lo  = cp[15:0];
            hit = (lo >= COMB0_LO && lo <= COMB0_HI) ||
                  (lo >= COMB1_LO && lo <= COMB1_HI) ||
                  (lo >= COMB2_LO && lo <= COMB2_HI) ||
                  (lo >= COMB3_LO && lo <= COMB3_HI) ||
                  (lo >= COMB4_LO && lo <= COMB4_HI);
            return hit && (cp[CP_BITS-1:16] == '0);
        end
    endfunction

endpackage

@@ rtl/core/utf8_grapheme_boundary_marker_core.sv @@
// UTF-8 grapheme boundary marker core: byte register, single-pass decode, result list.
// Depends on ugb_pkg for result type, combining ranges and sequence length.
//
//  channel | signals                                              | direction
//  --------+------------------------------------------------------+----------
//  in      | in_valid, in_ready, text_byte, final_byte            | request in
//  out     | out_valid, out_ready, boundary_offset,               | request out
//          | grapheme_number, end_of_text, grapheme_total         |
//
// A request is taken every cycle while the result list is free; it is held in the byte register
// and decoded in one pass into a list of zero to five results.
// The list drains one result per cycle while out_ready is high; the next byte is decoded into
// the list as its last result is taken, so a byte yielding n results holds the output until all are taken.
// Reset clears all text state; the next byte after an end result starts at offset 0.
// A stalled output holds the list and the byte register, then back-pressures the input.
module utf8_grapheme_boundary_marker_core #(
    parameter int OFFSET_BITS = ugb_pkg::OFFSET_BITS_DEFAULT
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  text_byte,
    input  logic        final_byte,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [31:0] boundary_offset,
    output logic [31:0] grapheme_number,
    output logic        end_of_text,
    output logic [31:0] grapheme_total
);

    localparam int IDX = ugb_pkg::RES_IDX_BITS;
    localparam int NR  = ugb_pkg::MAX_RESULTS;

    function automatic logic [OFFSET_BITS-1:0] sat_off(input logic [OFFSET_BITS-1:0] base,
                                                       input logic [2:0] inc);
        logic [OFFSET_BITS:0] sum;
        begin
            sum = {1'b0, base} + (OFFSET_BITS+1)'(inc);
            return sum[OFFSET_BITS] ? {OFFSET_BITS{1'b1}} : sum[OFFSET_BITS-1:0];
        end
    endfunction

    function automatic logic [31:0] clamp32(input logic [OFFSET_BITS-1:0] off);
        logic [OFFSET_BITS+31:0] ext;
        begin
            ext = {32'd0, off};
            return (|ext[OFFSET_BITS+31:32]) ? 32'hFFFF_FFFF : ext[31:0];
        end
    endfunction

    logic                   ivld_reg;
    logic [7:0]             ibyte_reg;
    logic                   ifin_reg;

    logic [7:0]             pend_reg [3];
    logic [1:0]             pend_cnt_reg;
    logic [OFFSET_BITS-1:0] byte_pos_reg;
    logic [OFFSET_BITS-1:0] lead_off_reg;
    logic                   seen_reg;
    logic [31:0]            bcount_reg;

    ugb_pkg::result_t       res_reg [NR];
    logic [IDX-1:0]         res_cnt_reg;
    logic [IDX-1:0]         rd_idx_reg;

    ugb_pkg::result_t       res_next [NR];
    logic [IDX-1:0]         res_cnt_next;
    logic                   seen_next;
    logic [31:0]            bcount_next;

    logic                   list_free;
    logic                   consume;
    logic [7:0]             buf_b [4];
    logic [2:0]             len;
    logic                   do_decode;
    logic [OFFSET_BITS-1:0] eff_lead;

    assign out_valid = rd_idx_reg < res_cnt_reg;
    assign list_free = !out_valid || (out_ready && (IDX'(rd_idx_reg + 1'b1) == res_cnt_reg));
    assign consume   = ivld_reg && list_free;
    assign in_ready  = !ivld_reg || consume;

    assign boundary_offset = res_reg[rd_idx_reg].offset;
    assign grapheme_number = res_reg[rd_idx_reg].number;
    assign end_of_text     = res_reg[rd_idx_reg].eot;
    assign grapheme_total  = res_reg[rd_idx_reg].total;

    always_comb
    begin
        for (int j = 0; j < 3; j++)
        begin
            buf_b[j] = pend_reg[j];
        end
        buf_b[3]            = 8'd0;
        buf_b[pend_cnt_reg] = ibyte_reg;
        len       = {1'b0, pend_cnt_reg} + 3'd1;
        do_decode = (len >= ugb_pkg::seq_length(buf_b[0])) || ifin_reg;
        eff_lead  = (pend_cnt_reg == 2'd0) ? byte_pos_reg : lead_off_reg;
    end

    always_comb
    begin
        logic [2:0]                      pos;
        logic [2:0]                      n;
        logic [7:0]                      c;
        logic [7:0]                      b1;
        logic [7:0]                      b2;
        logic [7:0]                      b3;
        logic [ugb_pkg::CP_BITS-1:0]     cp;
        logic [IDX-1:0]                  k;
        logic                            seen;
        logic [31:0]                     bc;
        pos  = 3'd0;
        n    = 3'd1;
        c    = 8'd0;
        b1   = 8'd0;
        b2   = 8'd0;
        b3   = 8'd0;
        cp   = '0;
        k    = '0;
        seen = seen_reg;
        bc   = bcount_reg;
        for (int j = 0; j < NR; j++)
        begin
            res_next[j] = '0;
        end
        if (do_decode)
        begin
            for (int s = 0; s < 4; s++)
            begin
                if (pos < len)
                begin
                    c  = buf_b[pos[1:0]];
                    b1 = buf_b[2'(pos + 3'd1)] & ugb_pkg::CONT_MASK;
                    b2 = buf_b[2'(pos + 3'd2)] & ugb_pkg::CONT_MASK;
                    b3 = buf_b[2'(pos + 3'd3)] & ugb_pkg::CONT_MASK;
                    n  = ugb_pkg::seq_length(c);
                    cp = {13'd0, c};
                    if (n > 3'd1 && (pos + n) <= len)
                    begin
                        case (n)
                            3'd2:    cp = {10'd0, c[4:0], b1[5:0]};
                            3'd3:    cp = {5'd0, c[3:0], b1[5:0], b2[5:0]};
                            default: cp = {c[2:0], b1[5:0], b2[5:0], b3[5:0]};
                        endcase
                    end
                    else
                    begin
                        n = 3'd1;
                    end
                    if (!ugb_pkg::is_combining(cp) || !seen)
                    begin
                        res_next[k].offset = clamp32(sat_off(eff_lead, pos));
                        res_next[k].number = bc;
                        k    = k + 1'b1;
                        bc   = (bc == 32'hFFFF_FFFF) ? bc : bc + 32'd1;
                        seen = 1'b1;
                    end
                    pos = pos + n;
                end
            end
        end
        if (ifin_reg)
        begin
            res_next[k].eot   = 1'b1;
            res_next[k].total = bc;
            k = k + 1'b1;
        end
        res_cnt_next = k;
        seen_next    = seen;
        bcount_next  = bc;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ivld_reg     <= 1'b0;
            pend_cnt_reg <= 2'd0;
            byte_pos_reg <= '0;
            lead_off_reg <= '0;
            seen_reg     <= 1'b0;
            bcount_reg   <= '0;
            res_cnt_reg  <= '0;
            rd_idx_reg   <= '0;
        end
        else
        begin
            if (in_valid && in_ready)
            begin
                ivld_reg <= 1'b1;
            end
            else if (consume)
            begin
                ivld_reg <= 1'b0;
            end

            if (consume)
            begin
                res_cnt_reg <= res_cnt_next;
                rd_idx_reg  <= '0;
                if (ifin_reg)
                begin
                    pend_cnt_reg <= 2'd0;
                    byte_pos_reg <= '0;
                    lead_off_reg <= '0;
                    seen_reg     <= 1'b0;
                    bcount_reg   <= '0;
                end
                else
                begin
                    byte_pos_reg <= sat_off(byte_pos_reg, 3'd1);
                    lead_off_reg <= eff_lead;
                    seen_reg     <= seen_next;
                    bcount_reg   <= bcount_next;
                    pend_cnt_reg <= do_decode ? 2'd0 : len[1:0];
                end
            end
            else if (out_valid && out_ready)
            begin
                rd_idx_reg <= rd_idx_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            ibyte_reg <= text_byte;
            ifin_reg  <= final_byte;
        end
        if (consume)
        begin
            for (int j = 0; j < NR; j++)
            begin
                res_reg[j] <= res_next[j];
            end
            if (!do_decode)
            begin
                for (int j = 0; j < 3; j++)
                begin
                    pend_reg[j] <= buf_b[j];
                end
            end
        end
    end

`ifndef SYNTHESIS
    a_list_bounds: assert property (@(posedge clk) disable iff (!rst_n)
        (res_cnt_reg <= IDX'(NR)) && (rd_idx_reg <= res_cnt_reg))
        else $error("result list index out of bounds");

    a_end_fields: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && end_of_text) |-> (boundary_offset == 32'd0 && grapheme_number == 32'd0))
        else $error("end result carries offset or number");

    a_boundary_total: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !end_of_text) |-> (grapheme_total == 32'd0))
        else $error("boundary result carries a total");

    a_text_restart: assert property (@(posedge clk) disable iff (!rst_n)
        (consume && ifin_reg) |=> (byte_pos_reg == '0 && bcount_reg == 32'd0 && !seen_reg
                                   && pend_cnt_reg == 2'd0))
        else $error("text state not cleared after final byte");
`endif

endmodule

@@ bench/tb_utf8_grapheme_boundary_marker_core.sv @@
// Self-checking bench for utf8_grapheme_boundary_marker_core: byte requests in, boundary results out.
// Predicts grapheme boundaries and end totals in place and compares each result.
// Depends on ugb_pkg and the core RTL only.
`timescale 1ns / 100ps

module tb_utf8_grapheme_boundary_marker_core;

    localparam longint unsigned OFFSET_MAX = 64'h0000_0000_FFFF_FFFF;
    localparam int CYCLE_LIMIT   = 200000;
    localparam int DRAIN_CYCLES  = 40;
    localparam int RANDOM_BYTES  = 70;
    localparam int REPORT_LIMIT  = 10;

    typedef struct {
        logic [7:0] value;
        logic       last;
    } text_req_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic [7:0]  text_byte = 8'h00;
    logic        final_byte = 1'b0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic [31:0] boundary_offset;
    logic [31:0] grapheme_number;
    logic        end_of_text;
    logic [31:0] grapheme_total;

    text_req_t          text_stream[$];
    ugb_pkg::result_t   expected_boundaries[$];

    logic [7:0]         pend_buf[0:2];
    int                 pend_cnt = 0;
    longint unsigned    next_pos = 0;
    longint unsigned    lead_pos = 0;
    logic               seen_first = 1'b0;
    logic [31:0]        bcount = '0;

    int          burst_left = 1;
    int          gap_left = 0;
    int          cycle_count = 0;
    int          stall_mode = 0;
    int          mismatches = 0;
    int          bytes_sent = 0;
    int          texts_sent = 0;
    int          boundaries_seen = 0;
    int          ends_seen = 0;

    logic [15:0] mark_lo[0:4] = '{16'h0300, 16'h1AB0, 16'h1DC0, 16'h20D0, 16'hFE20};
    logic [15:0] mark_hi[0:4] = '{16'h036F, 16'h1AFF, 16'h1DFF, 16'h20FF, 16'hFE2F};

    utf8_grapheme_boundary_marker_core i_dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .text_byte       (text_byte),
        .final_byte      (final_byte),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .boundary_offset (boundary_offset),
        .grapheme_number (grapheme_number),
        .end_of_text     (end_of_text),
        .grapheme_total  (grapheme_total)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    function automatic int lead_len(input logic [7:0] c);
        if (c[7:5] == 3'b110)
        begin
            return 2;
        end
        if (c[7:4] == 4'b1110)
        begin
            return 3;
        end
        if (c[7:3] == 5'b11110)
        begin
            return 4;
        end
        return 1;
    endfunction

    task automatic predict_boundaries(input logic [7:0] b, input logic fin);
        logic [7:0]       seq[0:3];
        int               len;
        int               i;
        int               n;
        logic [20:0]      cp;
        logic [15:0]      low;
        logic             mark;
        longint unsigned  off;
        ugb_pkg::result_t r;
        begin
            for (i = 0; i < pend_cnt; i++)
            begin
                seq[i] = pend_buf[i];
            end
            seq[pend_cnt] = b;
            len = pend_cnt + 1;
            if (pend_cnt == 0)
            begin
                lead_pos = next_pos;
            end
            if (next_pos < OFFSET_MAX)
            begin
                next_pos++;
            end
            if (len >= lead_len(seq[0]) || fin)
            begin
                i = 0;
                while (i < len)
                begin
                    n = lead_len(seq[i]);
                    cp = 21'(seq[i]);
                    if (n > 1 && i + n <= len)
                    begin
                        case (n)
                            2: cp = 21'({seq[i][4:0], seq[i+1][5:0]});
                            3: cp = 21'({seq[i][3:0], seq[i+1][5:0], seq[i+2][5:0]});
                            default: cp = {seq[i][2:0], seq[i+1][5:0], seq[i+2][5:0],
                                           seq[i+3][5:0]};
                        endcase
                    end
                    else
                    begin
                        n = 1;
                    end
                    low = cp[15:0];
                    mark = (cp[20:16] == 5'd0) &&
                           ((low >= 16'h0300 && low <= 16'h036F) ||
                            (low >= 16'h1AB0 && low <= 16'h1AFF) ||
                            (low >= 16'h1DC0 && low <= 16'h1DFF) ||
                            (low >= 16'h20D0 && low <= 16'h20FF) ||
                            (low >= 16'hFE20 && low <= 16'hFE2F));
                    if (!mark || !seen_first)
                    begin
                        off = lead_pos + longint'(i);
                        r.offset = (off > OFFSET_MAX) ? 32'hFFFF_FFFF : off[31:0];
                        r.number = bcount;
                        r.eot    = 1'b0;
                        r.total  = '0;
                        expected_boundaries.insert(expected_boundaries.size(), r);
                        if (bcount != 32'hFFFF_FFFF)
                        begin
                            bcount++;
                        end
                        seen_first = 1'b1;
                    end
                    i += n;
                end
                pend_cnt = 0;
            end
            else
            begin
                for (i = 0; i < len; i++)
                begin
                    pend_buf[i] = seq[i];
                end
                pend_cnt = len;
            end
            if (fin)
            begin
                r.offset = '0;
                r.number = '0;
                r.eot    = 1'b1;
                r.total  = bcount;
                expected_boundaries.insert(expected_boundaries.size(), r);
                pend_cnt   = 0;
                next_pos   = 0;
                lead_pos   = 0;
                seen_first = 1'b0;
                bcount     = '0;
            end
        end
    endtask

    task automatic push_byte(input logic [7:0] b);
        text_req_t t;
        begin
            t.value = b;
            t.last  = 1'b0;
            text_stream.insert(text_stream.size(), t);
        end
    endtask

    task automatic push_bytes(input logic [7:0] bytes[$]);
        begin
            foreach (bytes[k])
            begin
                push_byte(bytes[k]);
            end
            text_stream[text_stream.size() - 1].last = 1'b1;
        end
    endtask

    task automatic push_codepoint(input logic [20:0] cp);
        begin
            if (cp < 21'h80)
            begin
                push_byte(cp[7:0]);
            end
            else if (cp < 21'h800)
            begin
                push_byte({3'b110, cp[10:6]});
                push_byte({2'b10, cp[5:0]});
            end
            else if (cp < 21'h10000)
            begin
                push_byte({4'b1110, cp[15:12]});
                push_byte({2'b10, cp[11:6]});
                push_byte({2'b10, cp[5:0]});
            end
            else
            begin
                push_byte({5'b11110, cp[20:18]});
                push_byte({2'b10, cp[17:12]});
                push_byte({2'b10, cp[11:6]});
                push_byte({2'b10, cp[5:0]});
            end
        end
    endtask

    task automatic add_random_text();
        int          chars;
        int          c;
        int          kind;
        int          sel;
        int          n;
        int          k;
        logic [7:0]  lead;
        logic [20:0] cp;
        begin
            chars = ($urandom_range(0, 4) == 0) ? 1 : $urandom_range(2, 10);
            for (c = 0; c < chars; c++)
            begin
                kind = $urandom_range(0, 99);
                if (c == chars - 1 && $urandom_range(0, 3) == 0)
                begin
                    kind = 99;
                end
                if (kind < 30)
                begin
                    push_byte(8'($urandom_range(0, 127)));
                end
                else if (kind < 45)
                begin
                    push_codepoint(21'($urandom_range(32'h80, 32'h7FF)));
                end
                else if (kind < 60)
                begin
                    push_codepoint(21'($urandom_range(32'h800, 32'hFFFF)));
                end
                else if (kind < 68)
                begin
                    if ($urandom_range(0, 3) == 0)
                    begin
                        cp = {5'($urandom_range(1, 31)), 16'($urandom_range(16'h0300, 16'h036F))};
                    end
                    else
                    begin
                        cp = 21'($urandom_range(32'h10000, 32'h1FFFFF));
                    end
                    push_codepoint(cp);
                end
                else if (kind < 85)
                begin
                    sel = $urandom_range(0, 4);
                    push_codepoint(21'($urandom_range(mark_lo[sel], mark_hi[sel])));
                end
                else if (kind < 93)
                begin
                    if ($urandom_range(0, 1) == 0)
                    begin
                        push_byte(8'($urandom_range(8'h80, 8'hBF)));
                    end
                    else
                    begin
                        push_byte(8'($urandom_range(8'hF8, 8'hFF)));
                    end
                end
                else
                begin
                    case ($urandom_range(0, 2))
                        0: lead = {3'b110, 5'($urandom)};
                        1: lead = {4'b1110, 4'($urandom)};
                        default: lead = {5'b11110, 3'($urandom)};
                    endcase
                    n = lead_len(lead);
                    push_byte(lead);
                    for (k = 0; k < $urandom_range(0, n - 2); k++)
                    begin
                        push_byte(($urandom_range(0, 3) == 0) ? 8'($urandom) :
                                  {2'b10, 6'($urandom)});
                    end
                end
            end
            text_stream[text_stream.size() - 1].last = 1'b1;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        text_req_t t;
        if (!rst_n)
        begin
            in_valid   <= 1'b0;
            text_byte  <= 8'h00;
            final_byte <= 1'b0;
            burst_left <= 1;
            gap_left   <= 0;
        end
        else
        begin
            if (in_valid && in_ready)
            begin
                predict_boundaries(text_byte, final_byte);
                bytes_sent++;
                if (final_byte)
                begin
                    texts_sent++;
                end
            end
            if (!in_valid || in_ready)
            begin
                if (gap_left > 0)
                begin
                    gap_left <= gap_left - 1;
                    in_valid <= 1'b0;
                end
                else if (text_stream.size() > 0)
                begin
                    t = text_stream.pop_front();
                    text_byte  <= t.value;
                    final_byte <= t.last;
                    in_valid   <= 1'b1;
                    if (burst_left > 1)
                    begin
                        burst_left <= burst_left - 1;
                    end
                    else
                    begin
                        burst_left <= $urandom_range(1, 16);
                        gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                    end
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        ugb_pkg::result_t want;
        ugb_pkg::result_t got;
        if (!rst_n)
        begin
            out_ready <= 1'b0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                got.offset = boundary_offset;
                got.number = grapheme_number;
                got.eot    = end_of_text;
                got.total  = grapheme_total;
                if (end_of_text)
                begin
                    ends_seen++;
                end
                else
                begin
                    boundaries_seen++;
                end
                if (expected_boundaries.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= REPORT_LIMIT)
                    begin
                        $display("unexpected result: offset %0d number %0d eot %b total %0d",
                                 got.offset, got.number, got.eot, got.total);
                    end
                end
                else
                begin
                    want = expected_boundaries.pop_front();
                    if (got != want)
                    begin
                        mismatches++;
                        if (mismatches <= REPORT_LIMIT)
                        begin
                            $display("mismatch: expected offset %0d number %0d eot %b total %0d",
                                     want.offset, want.number, want.eot, want.total);
                            $display("          actual   offset %0d number %0d eot %b total %0d",
                                     got.offset, got.number, got.eot, got.total);
                        end
                    end
                end
            end
            case (stall_mode)
                0: out_ready <= 1'b1;
                1: out_ready <= ($urandom_range(0, 1) == 0);
                2: out_ready <= ($urandom_range(0, 3) == 0);
                default: out_ready <= cycle_count[0];
            endcase
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count % 50 == 0)
        begin
            stall_mode <= $urandom_range(0, 3);
        end
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycle_count);
            $display("Regression FAIL");
            $finish;
        end
    end

    initial
    begin
        int before_random;
        // lone bytes at both ends of the range
        push_bytes('{8'h00});
        push_bytes('{8'hFF});
        // leading mark, marks in two ranges, plane-1 lookalike, stray continuation
        push_bytes('{8'hCC, 8'h80, 8'h41, 8'hCD, 8'hAF, 8'hE2, 8'h83, 8'h90,
                     8'hF0, 8'h90, 8'h8C, 8'h80, 8'h80});
        // 3-byte lead whose second byte is a 2-byte lead; it still decodes as one 3-byte sequence
        push_bytes('{8'hE2, 8'hC3, 8'hA9});
        // largest 4-byte value
        push_bytes('{8'hF7, 8'hBF, 8'hBF, 8'hBF});
        // 4-byte lead cut after three bytes
        push_bytes('{8'hF4, 8'h80, 8'h80});
        before_random = text_stream.size();
        while (text_stream.size() - before_random < RANDOM_BYTES)
        begin
            add_random_text();
        end

        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        while (text_stream.size() != 0 || in_valid || expected_boundaries.size() != 0)
        begin
            @(negedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Sent %0d text bytes in %0d texts; checked %0d boundaries and %0d end totals.",
                 bytes_sent, texts_sent, boundaries_seen, ends_seen);
        $display("Mismatches: %0d, results still expected: %0d",
                 mismatches, expected_boundaries.size());
        if (mismatches == 0 && expected_boundaries.size() == 0)
        begin
            $display("Regression PASS");
        end
        else
        begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

@@ sim.f @@
rtl/core/ugb_pkg.sv
rtl/core/utf8_grapheme_boundary_marker_core.sv
bench/tb_utf8_grapheme_boundary_marker_core.sv
